// File: hdl/olir_pkg.sv
// Shared types and codes for the ordered list insert and remove core.
package olir_pkg;

	localparam int VALUE_W = 32;

	typedef enum logic [1:0] {
		OP_INS_FRONT = 2'd0,
		OP_INS_BACK  = 2'd1,
		OP_REMOVE    = 2'd2,
		OP_READ_ALL  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_WRITE,
		CMD_DROP,
		CMD_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      sel;
	} cell_ctrl_t;

	typedef struct packed {
		logic [1:0]                 opcode;
		logic signed [VALUE_W-1:0]  operand_value;
	} req_t;

	typedef struct packed {
		logic [1:0]                 status;
		logic signed [VALUE_W-1:0]  element_value;
		logic [3:0]                 element_index;
		logic                       has_element;
		logic [4:0]                 element_count;
		logic                       last;
	} res_t;

endpackage

// File: hdl/olir_cell.sv
// One storage cell of the list chain, moving its value to or from its neighbours.
module olir_cell (
	input  logic                              clk,
	input  olir_pkg::cell_ctrl_t              ctrl,
	input  logic signed [olir_pkg::VALUE_W-1:0] left,
	input  logic signed [olir_pkg::VALUE_W-1:0] right,
	input  logic signed [olir_pkg::VALUE_W-1:0] head,
	input  logic signed [olir_pkg::VALUE_W-1:0] operand,
	output logic signed [olir_pkg::VALUE_W-1:0] value
);

	logic signed [olir_pkg::VALUE_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			olir_pkg::CMD_PUSH: begin
				value_q <= left;
			end
			olir_pkg::CMD_WRITE: begin
				if (ctrl.sel) begin
					value_q <= operand;
				end
			end
			olir_pkg::CMD_DROP: begin
				value_q <= right;
			end
			// The tail cell takes the front value, so the list turns round by one.
			olir_pkg::CMD_ROTATE: begin
				value_q <= ctrl.sel ? head : right;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value = value_q;

endmodule

// File: hdl/ordered_list_insert_remove_core.sv
// Top level of the ordered list core: cell chain and its sequencer.
// The list lives in a chain of CAPACITY cells, front in cell 0. An insert at
// the front or back is applied at the edge that takes it, unless the list is
// full, and its result is registered at the same edge. A remove turns the
// chain round once after the cycle that takes it, each element passing the
// front cell where it is compared, and the first match is dropped instead of
// going to the back. A read out also turns the chain once after the cycle that
// takes it, giving one result a cycle for the first sixteen elements while
// the receiver does not stall. A read out of an empty list or a remove on an
// empty list is answered straight from the idle state. A new request is taken
// only when the previous one is finished and the result register is free or
// being emptied, so each stall of the receiver on a result holds the core
// back.
module ordered_list_insert_remove_core #(
	parameter int CAPACITY = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  olir_pkg::req_t   req,
	output logic             res_valid,
	input  logic             res_stall,
	output olir_pkg::res_t   res
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	state_t                              state_q, state_n;
	logic [CNT_W-1:0]                    count_q, count_n;
	logic [CNT_W-1:0]                    rem_q, rem_n;
	logic [CNT_W-1:0]                    step_q, step_n;
	logic                                found_q, found_n;
	logic signed [olir_pkg::VALUE_W-1:0] match_q, match_n;
	logic                                res_valid_q;
	olir_pkg::res_t                      res_q, res_n;
	logic                                load;
	logic                                can_load;
	logic                                accept;
	logic                                hit;
	logic                                emit;
	olir_pkg::cell_cmd_t                 cmd;
	logic [CNT_W-1:0]                    tail;
	logic [CNT_W+3:0]                    step_ext;

	logic signed [olir_pkg::VALUE_W-1:0] cell_val [CAPACITY];
	olir_pkg::cell_ctrl_t                cell_ctrl [CAPACITY];
	logic signed [olir_pkg::VALUE_W-1:0] head;

	assign head      = cell_val[0];
	assign tail      = count_q - CNT_W'(1);
	assign can_load  = !res_valid_q || !res_stall;
	assign req_stall = !((state_q == ST_IDLE) && can_load);
	assign accept    = req_valid && !req_stall;
	assign hit       = !found_q && (head == match_q);
	assign step_ext  = {4'b0, step_q};
	assign emit      = step_ext < (CNT_W + 4)'(16);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                                at_count;
		logic                                at_tail;
		logic signed [olir_pkg::VALUE_W-1:0] left;
		logic signed [olir_pkg::VALUE_W-1:0] right;

		assign at_count = (count_q == CNT_W'(i));
		assign at_tail  = (tail == CNT_W'(i));
		assign cell_ctrl[i].cmd = cmd;
		assign cell_ctrl[i].sel = (cmd == olir_pkg::CMD_WRITE) ? at_count : at_tail;

		if (i == 0) begin : g_first
			assign left = req.operand_value;
		end else begin : g_mid_left
			assign left = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = head;
		end else begin : g_mid_right
			assign right = cell_val[i+1];
		end

		olir_cell u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl[i]),
			.left    (left),
			.right   (right),
			.head    (head),
			.operand (req.operand_value),
			.value   (cell_val[i])
		);
	end

	always_comb begin
		cmd     = olir_pkg::CMD_HOLD;
		load    = 1'b0;
		res_n   = '0;
		state_n = state_q;
		count_n = count_q;
		rem_n   = rem_q;
		step_n  = step_q;
		found_n = found_q;
		match_n = match_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_n.last = 1'b1;
					case (req.opcode) inside
						olir_pkg::OP_INS_FRONT, olir_pkg::OP_INS_BACK: begin
							load = 1'b1;
							if (count_q != CNT_W'(CAPACITY)) begin
								cmd = (req.opcode == olir_pkg::OP_INS_FRONT) ?
									olir_pkg::CMD_PUSH : olir_pkg::CMD_WRITE;
								count_n = count_q + CNT_W'(1);
								res_n.status = olir_pkg::STAT_OK;
							end else begin
								res_n.status = olir_pkg::STAT_FULL;
							end
							res_n.element_count = 5'({5'b0, count_n});
						end
						olir_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								load = 1'b1;
								res_n.status = olir_pkg::STAT_NOT_FOUND;
							end else begin
								state_n = ST_SCAN;
								rem_n   = count_q;
								found_n = 1'b0;
								match_n = req.operand_value;
							end
						end
						default: begin
							if (count_q == '0) begin
								load = 1'b1;
								res_n.status = olir_pkg::STAT_OK;
							end else begin
								state_n = ST_READ;
								step_n  = '0;
							end
						end
					endcase
				end
			end
			ST_SCAN: begin
				if ((rem_q != CNT_W'(1)) || can_load) begin
					cmd   = hit ? olir_pkg::CMD_DROP : olir_pkg::CMD_ROTATE;
					rem_n = rem_q - CNT_W'(1);
					if (hit) begin
						count_n = count_q - CNT_W'(1);
						found_n = 1'b1;
					end
					if (rem_q == CNT_W'(1)) begin
						load    = 1'b1;
						state_n = ST_IDLE;
						res_n.status = (found_q || hit) ? olir_pkg::STAT_OK :
							olir_pkg::STAT_NOT_FOUND;
						res_n.element_count = 5'({5'b0, count_n});
						res_n.last = 1'b1;
					end
				end
			end
			ST_READ: begin
				if (!emit || can_load) begin
					cmd = olir_pkg::CMD_ROTATE;
					if (emit) begin
						load = 1'b1;
						res_n.status        = olir_pkg::STAT_OK;
						res_n.element_value = head;
						res_n.element_index = 4'({4'b0, step_q});
						res_n.has_element   = 1'b1;
						res_n.element_count = 5'({5'b0, count_q});
						res_n.last = (step_q == tail) ||
							(step_ext == (CNT_W + 4)'(15));
					end
					if (step_q == tail) begin
						state_n = ST_IDLE;
					end else begin
						step_n = step_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			rem_q   <= rem_n;
			step_q  <= step_n;
			found_q <= found_n;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		match_q <= match_n;
		if (load) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: hdl/olir_checker.sv
// Port-level checks on the result stream of the ordered list core, with its bind.
module olir_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_stall,
	input olir_pkg::res_t res
);

	// A result held back by the receiver stays in place.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// Only a read out gives more than one result per request.
	a_multi_is_read: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.has_element)
		else $error("non-final result without an element");

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.has_element |->
			(res.element_value == 0) && (res.element_index == 4'd0))
		else $error("element fields set on a result without an element");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status != olir_pkg::STAT_OK) |-> res.last && !res.has_element)
		else $error("failure status on an element result");

endmodule

bind ordered_list_insert_remove_core olir_checker u_olir_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// File: tb/ordered_list_insert_remove_core_tb.sv
// Self-checking testbench for the ordered list core: directed and random requests.
module ordered_list_insert_remove_core_tb;

	localparam int LIST_DEPTH = 16;
	localparam int READ_LIMIT = 16;
	localparam int POOL_SIZE = 8;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int NUM_PHASES = 4;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	olir_pkg::req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	olir_pkg::res_t res;

	olir_pkg::req_t requests_to_send[$];
	olir_pkg::res_t answers_due[$];
	logic signed [olir_pkg::VALUE_W-1:0] shadow_list[$];
	logic signed [olir_pkg::VALUE_W-1:0] value_pool[POOL_SIZE];
	int send_idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int items_queued = 0;

	ordered_list_insert_remove_core #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #1 clk = ~clk;

	function automatic olir_pkg::res_t list_answer(olir_pkg::status_t st,
			logic signed [olir_pkg::VALUE_W-1:0] val, int idx,
			logic has, int cnt, logic fin);
		olir_pkg::res_t a;
		a.status = st;
		a.element_value = val;
		a.element_index = idx[3:0];
		a.has_element = has;
		a.element_count = cnt[4:0];
		a.last = fin;
		return a;
	endfunction

	// Applies one request to the shadow list and queues the answers it must produce.
	task automatic apply_list_op(input olir_pkg::req_t r);
		int hit;
		int n;
		hit = -1;
		case (olir_pkg::opcode_t'(r.opcode))
			olir_pkg::OP_INS_FRONT, olir_pkg::OP_INS_BACK: begin
				if (shadow_list.size() < LIST_DEPTH) begin
					if (olir_pkg::opcode_t'(r.opcode) == olir_pkg::OP_INS_FRONT)
						shadow_list.push_front(r.operand_value);
					else
						shadow_list.push_back(r.operand_value);
					answers_due.push_back(list_answer(olir_pkg::STAT_OK, '0, 0, 1'b0,
						shadow_list.size(), 1'b1));
				end else begin
					answers_due.push_back(list_answer(olir_pkg::STAT_FULL, '0, 0, 1'b0,
						shadow_list.size(), 1'b1));
				end
			end
			olir_pkg::OP_REMOVE: begin
				foreach (shadow_list[i])
					if (hit < 0 && shadow_list[i] == r.operand_value)
						hit = i;
				if (hit >= 0) begin
					shadow_list.delete(hit);
					answers_due.push_back(list_answer(olir_pkg::STAT_OK, '0, 0, 1'b0,
						shadow_list.size(), 1'b1));
				end else begin
					answers_due.push_back(list_answer(olir_pkg::STAT_NOT_FOUND, '0, 0,
						1'b0, shadow_list.size(), 1'b1));
				end
			end
			default: begin
				if (shadow_list.size() == 0) begin
					answers_due.push_back(list_answer(olir_pkg::STAT_OK, '0, 0, 1'b0, 0,
						1'b1));
				end else begin
					n = (shadow_list.size() < READ_LIMIT) ? shadow_list.size() : READ_LIMIT;
					for (int i = 0; i < n; i++)
						answers_due.push_back(list_answer(olir_pkg::STAT_OK, shadow_list[i],
							i, 1'b1, shadow_list.size(), i == n - 1));
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [olir_pkg::VALUE_W-1:0] want,
			input logic [olir_pkg::VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Request driver: a new request is offered only once the previous one has gone.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!req_valid || !req_stall) begin
			if (requests_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req <= requests_to_send.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted request before checking any result at the same edge.
	always @(posedge clk or negedge arst_n) begin
		olir_pkg::res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				apply_list_op(req);
			if (res_valid && !res_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $time, res);
					error_count++;
				end else begin
					want = answers_due.pop_front();
					check_field("status", want.status, res.status);
					check_field("element_value", want.element_value, res.element_value);
					check_field("element_index", want.element_index, res.element_index);
					check_field("has_element", want.has_element, res.has_element);
					check_field("element_count", want.element_count, res.element_count);
					check_field("last", want.last, res.last);
				end
			end
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_op(input olir_pkg::opcode_t op,
			input logic signed [olir_pkg::VALUE_W-1:0] val);
		olir_pkg::req_t r;
		r.opcode = op;
		r.operand_value = val;
		requests_to_send.push_back(r);
		items_queued++;
	endtask

	// Mostly values from a small pool so that removals find their targets.
	function automatic logic signed [olir_pkg::VALUE_W-1:0] pick_value();
		if ($urandom_range(99) < 70)
			return value_pool[$urandom_range(POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic queue_random_burst();
		int kind;
		int len;
		int roll;
		olir_pkg::opcode_t op;
		kind = $urandom_range(2);
		len = (kind == 0) ? $urandom_range(12, 24) : $urandom_range(4, 16);
		for (int k = 0; k < len; k++) begin
			roll = $urandom_range(99);
			if (kind == 0 && roll < 85 || kind == 1 && roll < 10) begin
				if ($urandom_range(1))
					op = olir_pkg::OP_INS_BACK;
				else
					op = olir_pkg::OP_INS_FRONT;
			end else if (kind == 1 && roll < 85) begin
				op = olir_pkg::OP_REMOVE;
			end else begin
				op = olir_pkg::opcode_t'($urandom_range(3));
			end
			queue_op(op, pick_value());
		end
		if ($urandom_range(1))
			queue_op(olir_pkg::OP_READ_ALL, $urandom);
	endtask

	// Sampled on the falling edge, when every update of the rising edge has settled.
	task automatic wait_until_quiet();
		while (requests_to_send.size() != 0 || req_valid || answers_due.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int phase_end;
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7fff_ffff;
		value_pool[2] = '0;
		value_pool[3] = -1;
		for (int i = 4; i < POOL_SIZE; i++)
			value_pool[i] = $urandom;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Empty list: read out gives one empty result, a removal finds nothing.
		queue_op(olir_pkg::OP_READ_ALL, '0);
		queue_op(olir_pkg::OP_REMOVE, '0);
		queue_op(olir_pkg::OP_INS_FRONT, 32'sh8000_0000);
		queue_op(olir_pkg::OP_INS_BACK, 32'sh7fff_ffff);
		queue_op(olir_pkg::OP_INS_FRONT, -1);
		queue_op(olir_pkg::OP_INS_BACK, '0);
		queue_op(olir_pkg::OP_INS_BACK, -1);
		queue_op(olir_pkg::OP_INS_FRONT, 32'sd1);
		queue_op(olir_pkg::OP_READ_ALL, -1);
		// Of the two equal entries only the first one is to go.
		queue_op(olir_pkg::OP_REMOVE, -1);
		queue_op(olir_pkg::OP_REMOVE, 32'sd12345);
		queue_op(olir_pkg::OP_READ_ALL, 32'sh5555_aaaa);
		queue_op(olir_pkg::OP_REMOVE, 32'sh8000_0000);
		queue_op(olir_pkg::OP_REMOVE, 32'sd1);
		queue_op(olir_pkg::OP_REMOVE, 32'sh7fff_ffff);
		queue_op(olir_pkg::OP_READ_ALL, '0);
		queue_op(olir_pkg::OP_REMOVE, -1);
		queue_op(olir_pkg::OP_REMOVE, '0);
		queue_op(olir_pkg::OP_READ_ALL, '0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 55;
				end
				default: begin
					send_idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			phase_end = items_queued + ITEMS_PER_PHASE;
			while (items_queued < phase_end)
				queue_random_burst();
			wait_until_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && answers_due.size() == 0)
			$display("ordered_list_insert_remove_core_tb OK");
		else
			$display("ordered_list_insert_remove_core_tb NOT OK");
		$finish;
	end

	initial begin
		#400000;
		$display("ordered_list_insert_remove_core_tb NOT OK");
		$finish;
	end

endmodule
